// File: hw/rtl/dm64_pkg.sv
// shared types and constants for the 64-bit divide/modulo pipeline
package dm64_pkg;

   // width of the request and response data ports
   localparam int PORT_WIDTH = 64;

   // default operand width of the divider array
   localparam int DATA_WIDTH_DEFAULT = 64;

   // operation codes carried with each request
   typedef enum logic [1:0] {
      OP_UDIV = 2'b00,
      OP_UREM = 2'b01,
      OP_SDIV = 2'b10,
      OP_SREM = 2'b11
   } opcode_type;

   // sideband that travels down the array beside each request
   typedef struct packed {
      logic       valid;
      opcode_type op;
      logic       neg_n;
      logic       neg_d;
      logic       zero;
   } ctrl_type;

endpackage

// File: hw/rtl/divide_modulo_64bit_top.sv
// top level of the pipelined divide/modulo unit
// The unit takes one request on every clock and is never busy: busy stays low.
// Each request runs through an input stage, one divider cell per operand bit
// (DATA_WIDTH cells, one restoring step each) and an output stage, all
// registered; its response is strobed by rsp_valid for exactly one cycle, in
// request order. There is no back-pressure on the response side: the receiver
// must take every result in the cycle it shows.
// Only the low DATA_WIDTH bits of the operands are used and the result is
// zero-extended. A zero divisor gives 0; the most negative value divided by
// minus one wraps without any flag.
module divide_modulo_64bit_top #(
   parameter int DATA_WIDTH = dm64_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_opcode,
   input  logic [dm64_pkg::PORT_WIDTH-1:0] req_dividend,
   input  logic [dm64_pkg::PORT_WIDTH-1:0] req_divisor,
   output logic                            rsp_valid,
   output logic [dm64_pkg::PORT_WIDTH-1:0] rsp_result
);

   dm64_pkg::ctrl_type    ctrl_chain [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] rem_chain  [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] nq_chain   [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] d_chain    [DATA_WIDTH+1];

   // fully pipelined, never stalls
   assign busy = 1'b0;

   // operand preparation
   dm64_prep #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .req_take (start & ~busy),
      .req_op   (dm64_pkg::opcode_type'(req_opcode)),
      .req_n    (req_dividend),
      .req_d    (req_divisor),
      .ctrl_o   (ctrl_chain[0]),
      .n_o      (nq_chain[0]),
      .d_o      (d_chain[0])
   );

   assign rem_chain[0] = '0;

   // row of divider cells, most significant quotient bit first
   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      dm64_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctrl_i (ctrl_chain[i]),
         .rem_i  (rem_chain[i]),
         .nq_i   (nq_chain[i]),
         .d_i    (d_chain[i]),
         .ctrl_o (ctrl_chain[i+1]),
         .rem_o  (rem_chain[i+1]),
         .nq_o   (nq_chain[i+1]),
         .d_o    (d_chain[i+1])
      );
   end

   // sign fix-up and response register
   dm64_post #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_post (
      .clock      (clock),
      .reset      (reset),
      .ctrl_i     (ctrl_chain[DATA_WIDTH]),
      .rem_i      (rem_chain[DATA_WIDTH]),
      .quo_i      (nq_chain[DATA_WIDTH]),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

endmodule

// File: hw/rtl/dm64_prep.sv
// input stage: operand masking, magnitude conversion and zero-divisor detect
module dm64_prep #(
   parameter int DATA_WIDTH = dm64_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_take,
   input  dm64_pkg::opcode_type              req_op,
   input  logic [dm64_pkg::PORT_WIDTH-1:0]   req_n,
   input  logic [dm64_pkg::PORT_WIDTH-1:0]   req_d,
   output dm64_pkg::ctrl_type                ctrl_o,
   output logic [DATA_WIDTH-1:0]             n_o,
   output logic [DATA_WIDTH-1:0]             d_o
);

   logic [DATA_WIDTH-1:0] n_raw;
   logic [DATA_WIDTH-1:0] d_raw;
   logic                  is_signed;
   logic                  neg_n;
   logic                  neg_d;
   logic [DATA_WIDTH-1:0] n_in, n_ff;
   logic [DATA_WIDTH-1:0] d_in, d_ff;
   dm64_pkg::ctrl_type    ctrl_in, ctrl_ff;

   // low operand bits and sign handling
   always_comb begin
      n_raw     = req_n[DATA_WIDTH-1:0];
      d_raw     = req_d[DATA_WIDTH-1:0];
      is_signed = req_op inside {dm64_pkg::OP_SDIV, dm64_pkg::OP_SREM};
      neg_n     = is_signed & n_raw[DATA_WIDTH-1];
      neg_d     = is_signed & d_raw[DATA_WIDTH-1];
      n_in      = neg_n ? (~n_raw + 1'b1) : n_raw;
      d_in      = neg_d ? (~d_raw + 1'b1) : d_raw;
      ctrl_in.valid = req_take;
      ctrl_in.op    = req_op;
      ctrl_in.neg_n = neg_n;
      ctrl_in.neg_d = neg_d;
      ctrl_in.zero  = (d_raw == '0);
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
      n_ff <= n_in;
      d_ff <= d_in;
   end

   assign ctrl_o = ctrl_ff;
   assign n_o    = n_ff;
   assign d_o    = d_ff;

endmodule

// File: hw/rtl/dm64_cell.sv
// one restoring shift-subtract step of the divider array
module dm64_cell #(
   parameter int DATA_WIDTH = dm64_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dm64_pkg::ctrl_type    ctrl_i,
   input  logic [DATA_WIDTH-1:0] rem_i,
   input  logic [DATA_WIDTH-1:0] nq_i,
   input  logic [DATA_WIDTH-1:0] d_i,
   output dm64_pkg::ctrl_type    ctrl_o,
   output logic [DATA_WIDTH-1:0] rem_o,
   output logic [DATA_WIDTH-1:0] nq_o,
   output logic [DATA_WIDTH-1:0] d_o
);

   logic [DATA_WIDTH-1:0] shifted;
   logic [DATA_WIDTH:0]   diff;
   logic                  take;
   logic [DATA_WIDTH-1:0] rem_in, rem_ff;
   logic [DATA_WIDTH-1:0] nq_in, nq_ff;
   logic [DATA_WIDTH-1:0] d_ff;
   dm64_pkg::ctrl_type    ctrl_ff;

   // shift in the next dividend bit, trial subtract with the carried-out bit on top;
   // the dividend bits leave nq at the top while quotient bits enter at the bottom
   always_comb begin
      shifted = {rem_i[DATA_WIDTH-2:0], nq_i[DATA_WIDTH-1]};
      diff    = {rem_i[DATA_WIDTH-1], shifted} - {1'b0, d_i};
      take    = ~diff[DATA_WIDTH];
      rem_in  = take ? diff[DATA_WIDTH-1:0] : shifted;
      nq_in   = {nq_i[DATA_WIDTH-2:0], take};
   end

   // hand everything to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_i;
      end
      rem_ff <= rem_in;
      nq_ff  <= nq_in;
      d_ff   <= d_i;
   end

   assign ctrl_o = ctrl_ff;
   assign rem_o  = rem_ff;
   assign nq_o   = nq_ff;
   assign d_o    = d_ff;

endmodule

// File: hw/rtl/dm64_post.sv
// output stage: result select, sign fix-up and zero-divisor override
module dm64_post #(
   parameter int DATA_WIDTH = dm64_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dm64_pkg::ctrl_type              ctrl_i,
   input  logic [DATA_WIDTH-1:0]           rem_i,
   input  logic [DATA_WIDTH-1:0]           quo_i,
   output logic                            rsp_valid,
   output logic [dm64_pkg::PORT_WIDTH-1:0] rsp_result
);

   logic [DATA_WIDTH-1:0]           pick;
   logic                            flip;
   logic [DATA_WIDTH-1:0]           res;
   logic                            valid_in, valid_ff;
   logic [dm64_pkg::PORT_WIDTH-1:0] result_in, result_ff;

   // choose quotient or remainder and its sign
   always_comb begin
      case (ctrl_i.op)
         dm64_pkg::OP_UDIV: begin
            pick = quo_i;
            flip = 1'b0;
         end
         dm64_pkg::OP_UREM: begin
            pick = rem_i;
            flip = 1'b0;
         end
         dm64_pkg::OP_SDIV: begin
            pick = quo_i;
            flip = ctrl_i.neg_n ^ ctrl_i.neg_d;
         end
         dm64_pkg::OP_SREM: begin
            pick = rem_i;
            flip = ctrl_i.neg_n;
         end
         default: begin
            pick = quo_i;
            flip = 1'b0;
         end
      endcase
      res       = flip ? (~pick + 1'b1) : pick;
      valid_in  = ctrl_i.valid;
      result_in = ctrl_i.zero ? '0 : dm64_pkg::PORT_WIDTH'(res);
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// File: tb/divide_modulo_64bit_top_tb.sv
// self-checking testbench for the pipelined 64-bit divide/modulo unit
module divide_modulo_64bit_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int    OPERAND_BITS   = dm64_pkg::DATA_WIDTH_DEFAULT;
   localparam int    LATENCY        = OPERAND_BITS + 2;
   localparam int    RANDOM_ITEMS   = 1850;
   localparam int    QUIET_LIMIT    = 4000;
   localparam int    MAX_PRINTED    = 25;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;

   // one request waiting for its result
   typedef struct {
      dm64_pkg::opcode_type op;
      logic [63:0]          dividend;
      logic [63:0]          divisor;
      logic [63:0]          result;
   } division_type;

   // keeps the quotients and remainders still to come, in request order
   class division_checker_type;
      division_type expected_results[$];
      int unsigned  mismatches;
      int unsigned  compared;

      function new();
         mismatches = 0;
         compared   = 0;
      endfunction

      // restoring shift-subtract division on magnitudes, sign fix-up afterwards
      function logic [63:0] divide_predict(dm64_pkg::opcode_type op, logic [63:0] n,
                                           logic [63:0] d);
         logic [63:0] rem;
         logic [63:0] quo;
         logic        carry;
         logic        neg_n;
         logic        neg_d;
         rem   = '0;
         quo   = '0;
         neg_n = 1'b0;
         neg_d = 1'b0;
         if (op inside {dm64_pkg::OP_SDIV, dm64_pkg::OP_SREM}) begin
            if (n[63]) begin
               n     = ~n + 64'd1;
               neg_n = 1'b1;
            end
            if (d[63]) begin
               d     = ~d + 64'd1;
               neg_d = 1'b1;
            end
         end
         if (d != '0) begin
            for (int i = 63; i >= 0; i--) begin
               carry = rem[63];
               rem   = {rem[62:0], n[i]};
               if (carry || rem >= d) begin
                  rem    = rem - d;
                  quo[i] = 1'b1;
               end
            end
         end
         case (op)
            dm64_pkg::OP_UDIV: return quo;
            dm64_pkg::OP_UREM: return rem;
            dm64_pkg::OP_SDIV: return (neg_n != neg_d) ? ~quo + 64'd1 : quo;
            default:           return neg_n ? ~rem + 64'd1 : rem;
         endcase
      endfunction

      // one line per mismatch, quiet after the first few
      task report_mismatch(string what);
         if (mismatches < MAX_PRINTED)
            $display("%0t mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      function void note_request(dm64_pkg::opcode_type op, logic [63:0] n, logic [63:0] d);
         division_type item;
         item.op       = op;
         item.dividend = n;
         item.divisor  = d;
         item.result   = divide_predict(op, n, d);
         expected_results.push_back(item);
      endfunction

      task check_result(logic [63:0] got);
         division_type item;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %h with no request outstanding", got));
         end else begin
            item = expected_results.pop_front();
            compared++;
            if (got !== item.result)
               report_mismatch($sformatf("%s %h / %h: got %h, want %h", item.op.name(),
                                         item.dividend, item.divisor, got, item.result));
         end
      endtask

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        start        = 1'b0;
   logic [1:0]  req_opcode   = '0;
   logic [63:0] req_dividend = '0;
   logic [63:0] req_divisor  = '0;
   logic        busy;
   logic        rsp_valid;
   logic [63:0] rsp_result;

   division_checker_type board = new();
   int unsigned          op_count[4];
   int unsigned          zero_divisor_count;

   divide_modulo_64bit_top dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_dividend (req_dividend),
      .req_divisor  (req_divisor),
      .rsp_valid    (rsp_valid),
      .rsp_result   (rsp_result)
   );

   // clock
   always #5 clock = ~clock;

   // result monitor, sampled at the edge that takes the result
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result(rsp_result);
   end

   // watchdog: ends the run after a long stretch with no request or result taken
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid)
            quiet = 0;
         else
            quiet++;
      end
      $display("no progress for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // present one request; when may_idle is set, each cycle in front of it idles with a fixed chance
   task automatic send_request(input dm64_pkg::opcode_type op, input logic [63:0] n,
                               input logic [63:0] d, input bit may_idle);
      while (may_idle && $urandom_range(0, 99) < 18) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_opcode   <= op;
      req_dividend <= n;
      req_divisor  <= d;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(op, n, d);
      op_count[op]++;
      if (d == '0)
         zero_divisor_count++;
   endtask

   // hold requests off until every outstanding result has come back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // operand mix: full random, random widths, small values, edge values, negatives
   function automatic logic [63:0] random_operand();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2: ;
         3, 4:    v = v >> $urandom_range(0, 63);
         5:       v = 64'($urandom_range(0, 15));
         6: begin
            case ($urandom_range(0, 5))
               0: v = '0;
               1: v = 64'd1;
               2: v = ALL_ONES;
               3: v = MOST_NEG;
               4: v = MOST_POS;
               default: v = 64'd2;
            endcase
         end
         7:       v = ~64'($urandom_range(0, 15)) + 64'd1;
         default: v = ~(v >> $urandom_range(0, 63)) + 64'd1;
      endcase
      return v;
   endfunction

   // stimulus
   initial begin : stimulus
      dm64_pkg::opcode_type op;
      logic [63:0]          n;
      logic [63:0]          d;
      bit                   may_idle;

      for (int i = 0; i < 4; i++) op_count[i] = 0;
      zero_divisor_count = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero divisor on every operation
      send_request(dm64_pkg::OP_UDIV, 64'd0,    64'd0, 1'b0);
      send_request(dm64_pkg::OP_UREM, ALL_ONES, 64'd0, 1'b0);
      send_request(dm64_pkg::OP_SDIV, MOST_NEG, 64'd0, 1'b0);
      send_request(dm64_pkg::OP_SREM, ALL_ONES, 64'd0, 1'b0);
      // unsigned extremes, divisor with its top bit set
      send_request(dm64_pkg::OP_UDIV, ALL_ONES, 64'd1,    1'b0);
      send_request(dm64_pkg::OP_UREM, ALL_ONES, ALL_ONES, 1'b0);
      send_request(dm64_pkg::OP_UDIV, 64'd1,    ALL_ONES, 1'b0);
      send_request(dm64_pkg::OP_UREM, 64'd1,    ALL_ONES, 1'b0);
      send_request(dm64_pkg::OP_UDIV, ALL_ONES, 64'd2,    1'b0);
      send_request(dm64_pkg::OP_UREM, ALL_ONES, MOST_NEG, 1'b1);
      send_request(dm64_pkg::OP_UDIV, MOST_NEG, 64'd3,    1'b1);
      // most negative by minus one wraps, then other signed extremes
      send_request(dm64_pkg::OP_SDIV, MOST_NEG, ALL_ONES, 1'b1);
      send_request(dm64_pkg::OP_SREM, MOST_NEG, ALL_ONES, 1'b1);
      send_request(dm64_pkg::OP_SDIV, MOST_NEG, 64'd1,    1'b1);
      send_request(dm64_pkg::OP_SDIV, MOST_POS, ALL_ONES, 1'b1);
      send_request(dm64_pkg::OP_SREM, MOST_POS, MOST_NEG, 1'b1);
      // sign combinations of quotient and remainder
      send_request(dm64_pkg::OP_SDIV, -64'sd7, 64'sd2,  1'b1);
      send_request(dm64_pkg::OP_SDIV, 64'sd7,  -64'sd2, 1'b1);
      send_request(dm64_pkg::OP_SDIV, -64'sd7, -64'sd2, 1'b1);
      send_request(dm64_pkg::OP_SREM, -64'sd7, 64'sd2,  1'b1);
      send_request(dm64_pkg::OP_SREM, 64'sd7,  -64'sd2, 1'b1);
      send_request(dm64_pkg::OP_SREM, -64'sd7, -64'sd2, 1'b1);

      drain_results();

      // random part, back to back in the middle stretch
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         op       = dm64_pkg::opcode_type'($urandom_range(0, 3));
         n        = random_operand();
         d        = random_operand();
         may_idle = !(i >= 600 && i < 950);
         if (i == 1200)
            drain_results();
         send_request(op, n, d, may_idle);
      end
      start <= 1'b0;

      // wait out the pipeline, then a little more for stray results
      while (board.pending() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (board.pending() != 0)
         board.report_mismatch($sformatf("%0d results never came", board.pending()));

      $display("covered %0d requests: udiv %0d, urem %0d, sdiv %0d, srem %0d",
               op_count[0] + op_count[1] + op_count[2] + op_count[3],
               op_count[0], op_count[1], op_count[2], op_count[3]);
      $display("%0d with a zero divisor, %0d results compared, %0d mismatches",
               zero_divisor_count, board.compared, board.mismatches);
      if (board.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
